### sv/assert_macros.svh
// Assertion macros used by the mixer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that holds during reset as well.
`define ASSERT_CLK(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/qmm_pkg.sv
// Package with the widths, reset values, register codes and divide helper of the mixer.
`timescale 1ns / 1ps

package qmm_pkg;

   localparam int PULSE_W     = 12;
   localparam int CORR_W      = 11;
   localparam int MIX_W       = 14;
   localparam int FACTOR_W    = 14;
   localparam int PROD_W      = 28;
   localparam int RECIP_W     = 27;
   localparam int RECIP_SHIFT = 38;
   localparam int QUOT_W      = 18;
   localparam int NUM_MOTORS  = 4;
   localparam int CSR_ADDR_W  = 5;
   localparam int CSR_DATA_W  = 32;
   localparam int COMP_DIVISOR = 3000;

   // ceil(2**RECIP_SHIFT / COMP_DIVISOR); exact for every product magnitude below 2**28.
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / COMP_DIVISOR + 64'd1);

   typedef logic [PULSE_W-1:0]        pulse_type;
   typedef logic signed [CORR_W-1:0]  corr_type;
   typedef logic signed [MIX_W-1:0]   mix_type;
   typedef logic signed [PROD_W-1:0]  prod_type;
   typedef logic signed [QUOT_W-1:0]  quot_type;

   localparam pulse_type RST_THROTTLE_CEILING = PULSE_W'(1800);
   localparam pulse_type RST_PULSE_MIN        = PULSE_W'(1050);
   localparam pulse_type RST_PULSE_MAX        = PULSE_W'(2000);
   localparam pulse_type RST_DISARMED_PULSE   = PULSE_W'(1000);
   localparam pulse_type RST_COMP_WINDOW_LOW  = PULSE_W'(1100);
   localparam pulse_type RST_COMP_WINDOW_HIGH = PULSE_W'(1260);
   localparam pulse_type RST_COMP_REFERENCE   = PULSE_W'(1240);

   typedef enum logic [2:0] {
      CSR_THROTTLE_CEILING = 3'd0,
      CSR_PULSE_MIN        = 3'd1,
      CSR_PULSE_MAX        = 3'd2,
      CSR_DISARMED_PULSE   = 3'd3,
      CSR_COMP_WINDOW_LOW  = 3'd4,
      CSR_COMP_WINDOW_HIGH = 3'd5,
      CSR_COMP_REFERENCE   = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      MOTOR_FRONT_RIGHT = 2'd0,
      MOTOR_REAR_RIGHT  = 2'd1,
      MOTOR_REAR_LEFT   = 2'd2,
      MOTOR_FRONT_LEFT  = 2'd3
   } motor_index_type;

   // Signed division by COMP_DIVISOR, truncated toward zero, via a reciprocal multiply.
   function automatic quot_type div_by_divisor(input prod_type num);
      logic [PROD_W-1:0]         mag;
      logic [PROD_W+RECIP_W-1:0] wide;
      logic [QUOT_W-1:0]         quot;
      mag  = num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
      wide = {{RECIP_W{1'b0}}, mag} * {{PROD_W{1'b0}}, RECIP};
      quot = QUOT_W'(wide >> RECIP_SHIFT);
      return num[PROD_W-1] ? -$signed(quot) : $signed(quot);
   endfunction

endpackage

### sv/qmm_if.sv
// Valid/ready channel interfaces for the mixer's request and response.
`timescale 1ns / 1ps

interface qmm_req_if;
   logic                        valid;
   logic                        ready;
   qmm_pkg::pulse_type          throttle_in;
   qmm_pkg::corr_type           pitch_corr;
   qmm_pkg::corr_type           roll_corr;
   qmm_pkg::corr_type           yaw_corr;
   logic                        armed;
   qmm_pkg::pulse_type          battery_level;

   modport source (
      output valid, throttle_in, pitch_corr, roll_corr, yaw_corr, armed, battery_level,
      input  ready
   );
   modport sink (
      input  valid, throttle_in, pitch_corr, roll_corr, yaw_corr, armed, battery_level,
      output ready
   );
endinterface

interface qmm_rsp_if;
   logic                        valid;
   logic                        ready;
   qmm_pkg::pulse_type          motor_front_right;
   qmm_pkg::pulse_type          motor_rear_right;
   qmm_pkg::pulse_type          motor_rear_left;
   qmm_pkg::pulse_type          motor_front_left;

   modport source (
      output valid, motor_front_right, motor_rear_right, motor_rear_left, motor_front_left,
      input  ready
   );
   modport sink (
      input  valid, motor_front_right, motor_rear_right, motor_rear_left, motor_front_left,
      output ready
   );
endinterface

### sv/quad_motor_mixer.sv
// X-frame quadcopter motor mixer with battery compensation and pulse clamping.
//
//   Channel  Direction  Handshake        Carries
//   req_if   in         valid/ready      throttle, pitch/roll/yaw, armed, battery
//   rsp_if   out        valid/ready      four motor pulse widths
//   csr      in (APB)   psel/penable     seven 12-bit control registers
//
// One transaction is accepted per cycle unless the full pipeline is held by rsp_if; results leave there.
// The three stages are the input register, the mix-and-multiply register and the
// reciprocal-divide-and-clamp output register.
// A stalled response holds the pipeline; ready upstream stays high while any stage is free.
// Reset is synchronous; only control and valid registers are reset, and no clearing pass is needed.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module quad_motor_mixer (
   input  logic                                clock,
   input  logic                                reset,
   qmm_req_if.sink                             req_if,
   qmm_rsp_if.source                           rsp_if,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [qmm_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [qmm_pkg::CSR_DATA_W-1:0]      pwdata,
   output logic [qmm_pkg::CSR_DATA_W-1:0]      prdata,
   output logic                                pready
);

   // ---------------- control registers ----------------
   qmm_pkg::pulse_type throttle_ceiling_ff, pulse_min_ff, pulse_max_ff, disarmed_pulse_ff;
   qmm_pkg::pulse_type comp_window_low_ff, comp_window_high_ff, comp_reference_ff;
   qmm_pkg::csr_index_type csr_index;
   logic                   csr_write;
   qmm_pkg::pulse_type     csr_wdata;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = qmm_pkg::csr_index_type'(paddr[4:2]);
   assign csr_wdata = pwdata[qmm_pkg::PULSE_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         throttle_ceiling_ff <= qmm_pkg::RST_THROTTLE_CEILING;
         pulse_min_ff        <= qmm_pkg::RST_PULSE_MIN;
         pulse_max_ff        <= qmm_pkg::RST_PULSE_MAX;
         disarmed_pulse_ff   <= qmm_pkg::RST_DISARMED_PULSE;
         comp_window_low_ff  <= qmm_pkg::RST_COMP_WINDOW_LOW;
         comp_window_high_ff <= qmm_pkg::RST_COMP_WINDOW_HIGH;
         comp_reference_ff   <= qmm_pkg::RST_COMP_REFERENCE;
      end else if (csr_write) begin
         unique case (csr_index)
            qmm_pkg::CSR_THROTTLE_CEILING: throttle_ceiling_ff <= csr_wdata;
            qmm_pkg::CSR_PULSE_MIN:        pulse_min_ff        <= csr_wdata;
            qmm_pkg::CSR_PULSE_MAX:        pulse_max_ff        <= csr_wdata;
            qmm_pkg::CSR_DISARMED_PULSE:   disarmed_pulse_ff   <= csr_wdata;
            qmm_pkg::CSR_COMP_WINDOW_LOW:  comp_window_low_ff  <= csr_wdata;
            qmm_pkg::CSR_COMP_WINDOW_HIGH: comp_window_high_ff <= csr_wdata;
            qmm_pkg::CSR_COMP_REFERENCE:   comp_reference_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (csr_index)
         qmm_pkg::CSR_THROTTLE_CEILING: prdata = qmm_pkg::CSR_DATA_W'(throttle_ceiling_ff);
         qmm_pkg::CSR_PULSE_MIN:        prdata = qmm_pkg::CSR_DATA_W'(pulse_min_ff);
         qmm_pkg::CSR_PULSE_MAX:        prdata = qmm_pkg::CSR_DATA_W'(pulse_max_ff);
         qmm_pkg::CSR_DISARMED_PULSE:   prdata = qmm_pkg::CSR_DATA_W'(disarmed_pulse_ff);
         qmm_pkg::CSR_COMP_WINDOW_LOW:  prdata = qmm_pkg::CSR_DATA_W'(comp_window_low_ff);
         qmm_pkg::CSR_COMP_WINDOW_HIGH: prdata = qmm_pkg::CSR_DATA_W'(comp_window_high_ff);
         qmm_pkg::CSR_COMP_REFERENCE:   prdata = qmm_pkg::CSR_DATA_W'(comp_reference_ff);
         default:                       prdata = '0;
      endcase
   end

   // ---------------- pipeline flow control ----------------
   logic in_valid_ff, mid_valid_ff, out_valid_ff;
   logic adv_out, adv_mid, adv_in;

   assign adv_out      = !out_valid_ff || rsp_if.ready;
   assign adv_mid      = !mid_valid_ff || adv_out;
   assign adv_in       = !in_valid_ff  || adv_mid;
   assign req_if.ready = adv_in;
   assign rsp_if.valid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (adv_in)  in_valid_ff  <= req_if.valid;
         if (adv_mid) mid_valid_ff <= in_valid_ff;
         if (adv_out) out_valid_ff <= mid_valid_ff;
      end
   end

   // ---------------- stage 1: input register ----------------
   qmm_pkg::pulse_type throttle_ff, battery_ff;
   qmm_pkg::corr_type  pitch_ff, roll_ff, yaw_ff;
   logic               armed_ff;

   always_ff @(posedge clock) begin
      if (adv_in && req_if.valid) begin
         throttle_ff <= req_if.throttle_in;
         pitch_ff    <= req_if.pitch_corr;
         roll_ff     <= req_if.roll_corr;
         yaw_ff      <= req_if.yaw_corr;
         armed_ff    <= req_if.armed;
         battery_ff  <= req_if.battery_level;
      end
   end

   // ---------------- stage 2: mix and multiply by the compensation factor ----------------
   qmm_pkg::pulse_type                                 thr_cap;
   qmm_pkg::mix_type                                   thr_s, pitch_s, roll_s, yaw_s;
   logic signed [qmm_pkg::FACTOR_W-1:0]                factor;
   logic [qmm_pkg::NUM_MOTORS-1:0][qmm_pkg::MIX_W-1:0]  mix_in, mix_ff;
   logic [qmm_pkg::NUM_MOTORS-1:0][qmm_pkg::PROD_W-1:0] prod_in, prod_ff;
   logic                                               comp_in, comp_ff, mid_armed_ff;

   always_comb begin
      thr_cap = (throttle_ff > throttle_ceiling_ff) ? throttle_ceiling_ff : throttle_ff;
      thr_s   = $signed({{(qmm_pkg::MIX_W - qmm_pkg::PULSE_W){1'b0}}, thr_cap});
      pitch_s = qmm_pkg::MIX_W'(pitch_ff);
      roll_s  = qmm_pkg::MIX_W'(roll_ff);
      yaw_s   = qmm_pkg::MIX_W'(yaw_ff);

      mix_in[qmm_pkg::MOTOR_FRONT_RIGHT] = thr_s - pitch_s + roll_s - yaw_s;
      mix_in[qmm_pkg::MOTOR_REAR_RIGHT]  = thr_s + pitch_s + roll_s + yaw_s;
      mix_in[qmm_pkg::MOTOR_REAR_LEFT]   = thr_s + pitch_s - roll_s - yaw_s;
      mix_in[qmm_pkg::MOTOR_FRONT_LEFT]  = thr_s - pitch_s - roll_s + yaw_s;

      comp_in = (battery_ff < comp_window_high_ff) && (battery_ff > comp_window_low_ff);
      // The factor goes negative when the reference sits far below the voltage.
      factor  = $signed(qmm_pkg::FACTOR_W'(qmm_pkg::COMP_DIVISOR))
              + $signed({{(qmm_pkg::FACTOR_W - qmm_pkg::PULSE_W){1'b0}}, comp_reference_ff})
              - $signed({{(qmm_pkg::FACTOR_W - qmm_pkg::PULSE_W){1'b0}}, battery_ff});

      // Both operands are sign-extended to the product width before the multiply.
      for (int m = 0; m < qmm_pkg::NUM_MOTORS; m++) begin
         prod_in[m] = qmm_pkg::PROD_W'($signed(mix_in[m])) * qmm_pkg::PROD_W'(factor);
      end
   end

   always_ff @(posedge clock) begin
      if (adv_mid && in_valid_ff) begin
         mix_ff       <= mix_in;
         prod_ff      <= prod_in;
         comp_ff      <= comp_in;
         mid_armed_ff <= armed_ff;
      end
   end

   // ---------------- stage 3: divide, clamp, output register ----------------
   qmm_pkg::quot_type                                   value;
   qmm_pkg::quot_type                                   min_s, max_s;
   logic [qmm_pkg::NUM_MOTORS-1:0][qmm_pkg::PULSE_W-1:0] motor_in, motor_ff;
   logic                                                out_armed_ff;

   always_comb begin
      min_s = $signed({{(qmm_pkg::QUOT_W - qmm_pkg::PULSE_W){1'b0}}, pulse_min_ff});
      max_s = $signed({{(qmm_pkg::QUOT_W - qmm_pkg::PULSE_W){1'b0}}, pulse_max_ff});
      value = '0;
      for (int m = 0; m < qmm_pkg::NUM_MOTORS; m++) begin
         value = comp_ff ? qmm_pkg::div_by_divisor($signed(prod_ff[m]))
                         : qmm_pkg::QUOT_W'($signed(mix_ff[m]));
         // With inverted limits, values below the lower limit take it and all others take the upper limit.
         priority if (!mid_armed_ff) begin
            motor_in[m] = disarmed_pulse_ff;
         end else if (value < min_s) begin
            motor_in[m] = pulse_min_ff;
         end else if (value > max_s) begin
            motor_in[m] = pulse_max_ff;
         end else begin
            motor_in[m] = value[qmm_pkg::PULSE_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv_out && mid_valid_ff) begin
         motor_ff     <= motor_in;
         out_armed_ff <= mid_armed_ff;
      end
   end

   assign rsp_if.motor_front_right = motor_ff[qmm_pkg::MOTOR_FRONT_RIGHT];
   assign rsp_if.motor_rear_right  = motor_ff[qmm_pkg::MOTOR_REAR_RIGHT];
   assign rsp_if.motor_rear_left   = motor_ff[qmm_pkg::MOTOR_REAR_LEFT];
   assign rsp_if.motor_front_left  = motor_ff[qmm_pkg::MOTOR_FRONT_LEFT];

   // ---------------- assertions ----------------
   logic req_taken, mid_stalled, pipe_empty, disarmed_out, motors_match;

   assign req_taken    = req_if.valid && req_if.ready;
   assign mid_stalled  = out_valid_ff && !rsp_if.ready && mid_valid_ff;
   assign pipe_empty   = !in_valid_ff && !mid_valid_ff && !out_valid_ff;
   assign disarmed_out = out_valid_ff && !out_armed_ff;
   assign motors_match =
      (motor_ff[qmm_pkg::MOTOR_FRONT_RIGHT] == motor_ff[qmm_pkg::MOTOR_REAR_RIGHT]) &&
      (motor_ff[qmm_pkg::MOTOR_REAR_RIGHT]  == motor_ff[qmm_pkg::MOTOR_REAR_LEFT])  &&
      (motor_ff[qmm_pkg::MOTOR_REAR_LEFT]   == motor_ff[qmm_pkg::MOTOR_FRONT_LEFT]);

   `ASSERT_CLK_RST(a_accept_fills, clock, reset, req_taken |=> in_valid_ff, "transaction lost")
   `ASSERT_CLK_RST(a_mid_held, clock, reset, mid_stalled |=> $stable({mid_valid_ff, prod_ff, mix_ff}), "middle moved")
   `ASSERT_CLK_RST(a_disarmed, clock, reset, disarmed_out |-> motors_match, "motors differ")
   `ASSERT_CLK(a_empty_ready, clock, pipe_empty |-> req_if.ready, "empty pipeline stalled")

endmodule

### tb/tb_top.sv
// Self-checking testbench for the quad motor mixer, checking every response against a model.
`timescale 1ns / 1ps

module tb_top;
   import qmm_pkg::*;

   localparam int LATENCY         = 3;
   localparam int NUM_REGS        = 7;
   localparam int NUM_SETTINGS    = 8;
   localparam int ITEMS_PER_PHASE = 106;
   localparam logic [CSR_ADDR_W-1:0] UNMAPPED_CSR_ADDR = CSR_ADDR_W'(4 * NUM_REGS);

   typedef logic [NUM_MOTORS-1:0][PULSE_W-1:0] motor_set_type;

   // Holds the register copy and the queue of pulse sets still owed by the mixer.
   class motor_pulse_predictor;
      pulse_type     regs [NUM_REGS];
      motor_set_type expected_pulses [$];
      int            requests_noted;
      int            sets_checked;
      int            failures;
      string         motor_name [NUM_MOTORS];

      function new();
         regs[CSR_THROTTLE_CEILING] = RST_THROTTLE_CEILING;
         regs[CSR_PULSE_MIN]        = RST_PULSE_MIN;
         regs[CSR_PULSE_MAX]        = RST_PULSE_MAX;
         regs[CSR_DISARMED_PULSE]   = RST_DISARMED_PULSE;
         regs[CSR_COMP_WINDOW_LOW]  = RST_COMP_WINDOW_LOW;
         regs[CSR_COMP_WINDOW_HIGH] = RST_COMP_WINDOW_HIGH;
         regs[CSR_COMP_REFERENCE]   = RST_COMP_REFERENCE;
         motor_name[MOTOR_FRONT_RIGHT] = "motor_front_right";
         motor_name[MOTOR_REAR_RIGHT]  = "motor_rear_right";
         motor_name[MOTOR_REAR_LEFT]   = "motor_rear_left";
         motor_name[MOTOR_FRONT_LEFT]  = "motor_front_left";
      endfunction

      function void set_register(csr_index_type idx, pulse_type value);
         regs[idx] = value;
      endfunction

      function void note_request(pulse_type throttle, corr_type pitch, corr_type roll,
                                 corr_type yaw, logic armed, pulse_type battery);
         longint        thr;
         longint        factor;
         longint        mix [NUM_MOTORS];
         longint        lo;
         longint        hi;
         motor_set_type pulses;
         requests_noted++;
         if (!armed) begin
            for (int i = 0; i < NUM_MOTORS; i++) pulses[i] = regs[CSR_DISARMED_PULSE];
         end else begin
            thr = longint'(throttle);
            if (thr > longint'(regs[CSR_THROTTLE_CEILING]))
               thr = longint'(regs[CSR_THROTTLE_CEILING]);
            mix[MOTOR_FRONT_RIGHT] = thr - pitch + roll - yaw;
            mix[MOTOR_REAR_RIGHT]  = thr + pitch + roll + yaw;
            mix[MOTOR_REAR_LEFT]   = thr + pitch - roll - yaw;
            mix[MOTOR_FRONT_LEFT]  = thr - pitch - roll + yaw;
            if (battery < regs[CSR_COMP_WINDOW_HIGH] && battery > regs[CSR_COMP_WINDOW_LOW]) begin
               // The factor may go negative when the reference sits far below the voltage.
               factor = COMP_DIVISOR + longint'(regs[CSR_COMP_REFERENCE]) - longint'(battery);
               for (int i = 0; i < NUM_MOTORS; i++) mix[i] = (mix[i] * factor) / COMP_DIVISOR;
            end
            lo = longint'(regs[CSR_PULSE_MIN]);
            hi = longint'(regs[CSR_PULSE_MAX]);
            for (int i = 0; i < NUM_MOTORS; i++) begin
               if (mix[i] < lo) mix[i] = lo;
               else if (mix[i] > hi) mix[i] = hi;
               pulses[i] = pulse_type'(mix[i]);
            end
         end
         expected_pulses.push_back(pulses);
      endfunction

      function void check_pulses(motor_set_type got);
         motor_set_type want;
         if (expected_pulses.size() == 0) begin
            $error("motor pulse set %h arrived with no request outstanding", got);
            failures++;
            return;
         end
         want = expected_pulses.pop_front();
         sets_checked++;
         for (int i = 0; i < NUM_MOTORS; i++) begin
            if (got[i] !== want[i]) begin
               $error("%s: expected %0d, got %0d", motor_name[i], want[i], got[i]);
               failures++;
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   qmm_req_if req_if ();
   qmm_rsp_if rsp_if ();

   motor_pulse_predictor pulses;
   int send_idle_pct;
   int stall_pct;

   // Register settings in register order: ceiling, min, max, disarmed, window low, high, reference.
   pulse_type settings [NUM_SETTINGS][NUM_REGS] = '{
      '{1800, 1050, 2000, 1000, 1100, 1260, 1240},
      '{   0,    0,    0,    0,    0,    0,    0},
      '{4095, 4095, 4095, 4095, 4095, 4095, 4095},
      '{4095,    0, 4095, 2048,    0, 4095, 4095},
      '{4095,    0, 4095,    1, 3000, 4095,    0},
      '{2500, 2600,  900, 4095,  500, 1500, 1000},
      '{3000,  100, 3900,    0, 2000, 1000, 2000},
      '{2200, 1100, 1900,  950, 1000, 1400, 1300}
   };

   quad_motor_mixer DUT (
      .clock   (clock),
      .reset   (reset),
      .req_if  (req_if),
      .rsp_if  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // The response side stalls at random according to the current phase.
   always @(negedge clock) begin
      rsp_if.ready <= !reset && ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         pulses.check_pulses({rsp_if.motor_front_left, rsp_if.motor_rear_left,
                              rsp_if.motor_rear_right, rsp_if.motor_front_right});
   end

   // Ends with psel low after the access, so back-to-back writes never collide.
   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   // Upper data bits are filled with noise; only the low twelve bits are kept.
   task automatic write_register(csr_index_type idx, pulse_type value);
      csr_write(CSR_ADDR_W'(4 * idx), {(CSR_DATA_W - PULSE_W)'($urandom), value});
      pulses.set_register(idx, value);
   endtask

   task automatic send_request(pulse_type throttle, corr_type pitch, corr_type roll,
                               corr_type yaw, logic armed, pulse_type battery);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.throttle_in   <= throttle;
      req_if.pitch_corr    <= pitch;
      req_if.roll_corr     <= roll;
      req_if.yaw_corr      <= yaw;
      req_if.armed         <= armed;
      req_if.battery_level <= battery;
      do @(posedge clock); while (!req_if.ready);
      pulses.note_request(throttle, pitch, roll, yaw, armed, battery);
      @(negedge clock);
   endtask

   // Mostly armed requests, with the voltage often placed inside the compensation window.
   task automatic send_random_request();
      int        lo;
      int        hi;
      int        thr;
      pulse_type battery;
      lo  = pulses.regs[CSR_COMP_WINDOW_LOW];
      hi  = pulses.regs[CSR_COMP_WINDOW_HIGH];
      thr = $urandom_range(4095);
      if ($urandom_range(3) == 0) begin
         thr = pulses.regs[CSR_THROTTLE_CEILING] + $urandom_range(8) - 4;
         if (thr < 0) thr = 0;
         if (thr > 4095) thr = 4095;
      end
      case ($urandom_range(7))
         0: battery = pulse_type'(lo);
         1: battery = pulse_type'(hi);
         2, 3: battery = pulse_type'($urandom_range(4095));
         default: battery = (hi > lo + 1) ? pulse_type'($urandom_range(hi - 1, lo + 1))
                                          : pulse_type'($urandom_range(4095));
      endcase
      send_request(pulse_type'(thr), corr_type'($urandom_range(2047)),
                   corr_type'($urandom_range(2047)), corr_type'($urandom_range(2047)),
                   $urandom_range(9) != 0, battery);
   endtask

   task automatic wait_drained();
      while (pulses.expected_pulses.size() != 0) @(negedge clock);
      repeat (LATENCY + 2) @(negedge clock);
   endtask

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

   initial begin
      pulses               = new();
      send_idle_pct        = 0;
      stall_pct            = 0;
      reset                = 1'b1;
      psel                 = 1'b0;
      penable              = 1'b0;
      pwrite               = 1'b0;
      paddr                = '0;
      pwdata               = '0;
      req_if.valid         = 1'b0;
      req_if.throttle_in   = '0;
      req_if.pitch_corr    = '0;
      req_if.roll_corr     = '0;
      req_if.yaw_corr      = '0;
      req_if.armed         = 1'b0;
      req_if.battery_level = '0;
      rsp_if.ready         = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed requests under the reset register values.
      send_request(4095, -1024, -1024, -1024, 1'b0, 4095);
      send_request(0, 1023, 1023, 1023, 1'b0, 0);
      send_request(0, 0, 0, 0, 1'b1, 0);
      send_request(4095, 1023, 1023, 1023, 1'b1, 4095);
      send_request(4095, -1024, -1024, -1024, 1'b1, 4095);
      send_request(1800, 0, 0, 0, 1'b1, 0);
      send_request(1801, 0, 0, 0, 1'b1, 0);
      send_request(1500, 300, -200, 100, 1'b1, 1100);
      send_request(1500, 300, -200, 100, 1'b1, 1101);
      send_request(1500, 300, -200, 100, 1'b1, 1259);
      send_request(1500, 300, -200, 100, 1'b1, 1260);
      send_request(1500, 300, -200, 100, 1'b1, 1240);
      // Mixes below zero pass through the truncating scale before the lower clamp.
      send_request(0, 1023, -1024, 1023, 1'b1, 1200);
      send_request(0, -1024, 1023, 1023, 1'b1, 1105);
      send_request(100, 1023, 1023, -1024, 1'b1, 1150);
      send_request(12'h555, 11'h2AA, 11'h555, 11'h2AA, 1'b1, 12'hAAA);
      send_request(12'hAAA, 11'h555, 11'h2AA, 11'h555, 1'b1, 12'h555);
      send_request(1700, -700, 650, -400, 1'b1, 1101);
      send_request(1200, 5, -5, 3, 1'b1, 1259);
      send_request(2000, 0, 0, 0, 1'b1, 1180);
      req_if.valid <= 1'b0;
      wait_drained();

      for (int s = 0; s < NUM_SETTINGS; s++) begin
         for (int r = 0; r < NUM_REGS; r++) write_register(csr_index_type'(r), settings[s][r]);
         // A write past the last register must leave every setting as it was.
         if (s == 1) csr_write(UNMAPPED_CSR_ADDR, CSR_DATA_W'($urandom));
         case (s % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 82; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 82; end
            default: begin send_idle_pct = 28; stall_pct = 28; end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random_request();
         req_if.valid <= 1'b0;
         send_idle_pct = 0;
         stall_pct     = 0;
         wait_drained();
      end

      $display("Checked %0d motor pulse sets from %0d requests.",
               pulses.sets_checked, pulses.requests_noted);
      $display("Covered %0d register settings, including empty, inverted and extreme ones.",
               NUM_SETTINGS);
      if (pulses.failures == 0 && pulses.expected_pulses.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
